### hw/rtl/led_matrix_bitplane_scanner_defines.svh
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner: assertion macros
// Shared property wrappers clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LED_MATRIX_BITPLANE_SCANNER_DEFINES_SVH
`define LED_MATRIX_BITPLANE_SCANNER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMBS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/lmbs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner package
// Panel geometry, field widths and the structures passed between modules.
// ----------------------------------------------------------------------------
package lmbs_pkg;

  // Panel geometry
  localparam int PANEL_COLUMNS = 32;
  localparam int ROW_PAIRS     = 16;
  localparam int COLOUR_BITS   = 8;

  localparam int COL_W      = $clog2(PANEL_COLUMNS);
  localparam int PAIR_W     = $clog2(ROW_PAIRS);
  localparam int ROW_W      = PAIR_W + 1;
  localparam int PLANE_W    = 3;
  localparam int ADDR_OUT_W = 4;

  // Each half of the panel has its own store, addressed by {row pair, column}
  localparam int HALF_DEPTH = PANEL_COLUMNS * ROW_PAIRS;
  localparam int HALF_AW    = $clog2(HALF_DEPTH);

  // Stream widths
  localparam int IN_FIELDS_W = COL_W + ROW_W + 2 * COLOUR_BITS + PLANE_W;
  localparam int S_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 6 + ADDR_OUT_W;
  localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation codes carried on s_axis_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SHIFT = 1'b1;

  // Input payload, last field in the lowest bits
  typedef struct packed {
    logic [PLANE_W-1:0]     plane_sel;
    logic [COLOUR_BITS-1:0] blue_value;
    logic [COLOUR_BITS-1:0] red_value;
    logic [ROW_W-1:0]       pixel_row;
    logic [COL_W-1:0]       pixel_col;
  } in_data_t;

  // One frame store entry
  typedef struct packed {
    logic [COLOUR_BITS-1:0] red;
    logic [COLOUR_BITS-1:0] blue;
  } pixel_t;

  // Pixel write into one half of the store
  typedef struct packed {
    logic               valid;
    logic               lower;
    logic [HALF_AW-1:0] addr;
    pixel_t             pixel;
  } store_wr_t;

  // Scan position presented for the next shift step
  typedef struct packed {
    logic [PAIR_W-1:0]     pair;
    logic [COL_W-1:0]      col;
    logic                  end_of_row;
    logic [ADDR_OUT_W-1:0] drv_addr;
  } scan_req_t;

  // Result payload, last field in the lowest bits
  typedef struct packed {
    logic [ADDR_OUT_W-1:0] row_address;
    logic                  latch_pulse;
    logic                  shift_pulse;
    logic                  lower_blue;
    logic                  lower_red;
    logic                  upper_blue;
    logic                  upper_red;
  } result_t;

endpackage

### hw/rtl/lmbs_frame_store.sv
// ----------------------------------------------------------------------------
// LED matrix frame store
// Two synchronous memories, one per panel half, with a clearing pass after
// reset and registered reads of the same address in both halves.
// ----------------------------------------------------------------------------
module lmbs_frame_store (
  input  logic                        clk,
  input  logic                        rst,
  input  lmbs_pkg::store_wr_t         wr,
  input  logic                        rd_en,
  input  logic [lmbs_pkg::HALF_AW-1:0] rd_addr,
  output lmbs_pkg::pixel_t            upper_q,
  output lmbs_pkg::pixel_t            lower_q,
  output logic                        busy
);
  import lmbs_pkg::*;

  pixel_t             upper_mem [HALF_DEPTH];
  pixel_t             lower_mem [HALF_DEPTH];
  logic               clearing;
  logic [HALF_AW-1:0] clr_addr;

  // Clearing sweep, one entry of each half per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + HALF_AW'(1);
      if (clr_addr == HALF_AW'(HALF_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (clearing) begin
      upper_mem[clr_addr] <= '0;
      lower_mem[clr_addr] <= '0;
    end else if (wr.valid) begin
      if (wr.lower) begin
        lower_mem[wr.addr] <= wr.pixel;
      end else begin
        upper_mem[wr.addr] <= wr.pixel;
      end
    end
    if (rd_en) begin
      upper_q <= upper_mem[rd_addr];
      lower_q <= lower_mem[rd_addr];
    end
  end

  assign busy = clearing;

endmodule

### hw/rtl/lmbs_scan_ctrl.sv
// ----------------------------------------------------------------------------
// LED matrix scan control
// Column and row pair counters and the row address driven on the panel.
// ----------------------------------------------------------------------------
module lmbs_scan_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  output lmbs_pkg::scan_req_t  req
);
  import lmbs_pkg::*;

  logic [COL_W-1:0]      column_count;
  logic [PAIR_W-1:0]     row_pair_count;
  logic [ADDR_OUT_W-1:0] driven_address;
  logic                  end_of_row;

  assign end_of_row = (column_count == COL_W'(PANEL_COLUMNS - 1));

  // Current position for the next shift step.
  always_comb begin
    req.pair       = row_pair_count;
    req.col        = column_count;
    req.end_of_row = end_of_row;
    req.drv_addr   = driven_address;
  end

  // Advance the scan on every accepted shift step.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      row_pair_count <= '0;
      driven_address <= '0;
    end else if (step) begin
      if (end_of_row) begin
        column_count   <= '0;
        driven_address <= ADDR_OUT_W'(row_pair_count);
        if (row_pair_count == PAIR_W'(ROW_PAIRS - 1)) begin
          row_pair_count <= '0;
        end else begin
          row_pair_count <= row_pair_count + PAIR_W'(1);
        end
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

endmodule

### hw/rtl/lmbs_result_stage.sv
// ----------------------------------------------------------------------------
// LED matrix result stage
// Holds a shift step while its store read completes, then issues the shift
// result and, at the end of a row, the latch result into the output register.
// ----------------------------------------------------------------------------
module lmbs_result_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  lmbs_pkg::scan_req_t            req,
  input  logic [lmbs_pkg::PLANE_W-1:0]   plane,
  input  lmbs_pkg::pixel_t               upper_q,
  input  lmbs_pkg::pixel_t               lower_q,
  output logic                           take,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lmbs_pkg::result_t              out_data,
  output logic                           out_last
);
  import lmbs_pkg::*;

  // Step waiting on its read data
  logic                  s1_valid;
  logic                  s1_phase;
  logic                  s1_eor;
  logic [PAIR_W-1:0]     s1_pair;
  logic [ADDR_OUT_W-1:0] s1_drv;
  logic [PLANE_W-1:0]    s1_plane;

  logic                  out_free;
  logic                  s1_emit;
  logic                  s1_done;
  result_t               emit_data;
  logic                  emit_last;

  assign out_free = !out_valid || out_ready;
  assign s1_emit  = s1_valid && out_free;
  assign s1_done  = s1_emit && (!s1_eor || s1_phase);
  assign take     = !s1_valid || s1_done;

  // Shift result first, latch result second.
  always_comb begin
    emit_data = '0;
    if (s1_phase) begin
      emit_data.latch_pulse = 1'b1;
      emit_data.row_address = ADDR_OUT_W'(s1_pair);
      emit_last             = 1'b1;
    end else begin
      emit_data.upper_red   = upper_q.red[s1_plane];
      emit_data.upper_blue  = upper_q.blue[s1_plane];
      emit_data.lower_red   = lower_q.red[s1_plane];
      emit_data.lower_blue  = lower_q.blue[s1_plane];
      emit_data.shift_pulse = 1'b1;
      emit_data.row_address = s1_drv;
      emit_last             = !s1_eor;
    end
  end

  // Control of the holding stage and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s1_phase  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
        s1_phase <= 1'b0;
      end else if (s1_done) begin
        s1_valid <= 1'b0;
      end else if (s1_emit) begin
        s1_phase <= 1'b1;
      end
      if (s1_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      s1_eor   <= req.end_of_row;
      s1_pair  <= req.pair;
      s1_drv   <= req.drv_addr;
      s1_plane <= plane;
    end
    if (s1_emit) begin
      out_data <= emit_data;
      out_last <= emit_last;
    end
  end

endmodule

### hw/rtl/led_matrix_bitplane_scanner.sv
// ----------------------------------------------------------------------------
// LED matrix bit-plane scanner
// Frame store and scan sequencer for a 32x32 scan-split panel, red and blue.
// ----------------------------------------------------------------------------
// After reset the frame store runs a clearing pass over its 512 entries per
// half with s_axis_tready low; after that a write transfer (tuser 0) stores
// one pixel and a shift transfer (tuser 1) reads the current column of the
// upper and lower row of the current row pair from two memories, one per
// panel half. One transfer is accepted per cycle while s_axis_tready is high;
// a shift step at the last column holds the input while its latch result
// goes out, since the result stage issues one result per cycle while the
// output is ready. The shift step waits in the holding stage and its result
// is registered in the output register, and back-pressure on the output
// stalls the input only once the holding stage and output register are full.
`include "led_matrix_bitplane_scanner_defines.svh"

module led_matrix_bitplane_scanner (
  input  logic                             clk,
  input  logic                             rst,
  // pixel_col[4:0], pixel_row[9:5], red_value[17:10], blue_value[25:18],
  // plane_sel[28:26]
  input  logic [lmbs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // operation[0]
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // upper_red[0], upper_blue[1], lower_red[2], lower_blue[3],
  // shift_pulse[4], latch_pulse[5], row_address[9:6]
  output logic [lmbs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready
);
  import lmbs_pkg::*;

  in_data_t  in_word;
  logic      accept;
  logic      shift_step;
  logic      busy;
  logic      take;
  store_wr_t wr;
  scan_req_t req;
  pixel_t    upper_q;
  pixel_t    lower_q;
  result_t   result;

  assign in_word       = in_data_t'(s_axis_tdata[IN_FIELDS_W-1:0]);
  assign s_axis_tready = take && !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign shift_step    = accept && (s_axis_tuser == OP_SHIFT);

  // Pixel write into the half selected by the top row bit.
  always_comb begin
    wr.valid      = accept && (s_axis_tuser == OP_WRITE);
    wr.lower      = in_word.pixel_row[ROW_W-1];
    wr.addr       = {in_word.pixel_row[PAIR_W-1:0], in_word.pixel_col};
    wr.pixel.red  = in_word.red_value;
    wr.pixel.blue = in_word.blue_value;
  end

  lmbs_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_en   (shift_step),
    .rd_addr ({req.pair, req.col}),
    .upper_q (upper_q),
    .lower_q (lower_q),
    .busy    (busy)
  );

  lmbs_scan_ctrl u_scan (
    .clk  (clk),
    .rst  (rst),
    .step (shift_step),
    .req  (req)
  );

  lmbs_result_stage u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (shift_step),
    .req       (req),
    .plane     (in_word.plane_sel),
    .upper_q   (upper_q),
    .lower_q   (lower_q),
    .take      (take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (result),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(M_TDATA_W - OUT_FIELDS_W){1'b0}}, result};

  // Checks on the sequencing of this block.
  `LMBS_ASSERT_SAME(a_no_accept_while_clearing, busy, !s_axis_tready,
    "transfer accepted during the clearing pass")
  `LMBS_ASSERT_SAME(a_latch_result_form, m_axis_tvalid && result.latch_pulse,
    m_axis_tlast && !result.shift_pulse && (result[3:0] == 4'b0000),
    "latch result with data bits, shift pulse or without last")
  `LMBS_ASSERT_NEXT(a_end_of_row_holds_input, shift_step && req.end_of_row,
    !s_axis_tready, "input accepted before the latch result was issued")

endmodule
